### design/greedy_relation_excess_filter_top_macros.svh
// ----------------------------------------------------------------------------
// greedy relation excess filter assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef GREEDY_RELATION_EXCESS_FILTER_TOP_MACROS_SVH
`define GREEDY_RELATION_EXCESS_FILTER_TOP_MACROS_SVH

`ifndef SYNTH
// property that must hold at every edge outside reset
`define GRF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same edge implication
`define GRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define GRF_ASSERT(lbl, clk, rst_n, prop, msg)
`define GRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/grefilt_pkg.sv
// ----------------------------------------------------------------------------
// grefilt_pkg
// shared widths, limits and the result type of the relation excess filter
// ----------------------------------------------------------------------------
package grefilt_pkg;

    // defaults for the top level parameters
    localparam int NUM_IDEALS_DEF     = 65536;
    localparam int MAX_REL_IDEALS_DEF = 32;

    // fixed field widths
    localparam int IDX_IN_W  = 16;
    localparam int TGT_W     = 16;
    localparam int NEWO_W    = 6;
    localparam int KEPT_W    = 20;
    localparam int COVER_W   = 17;
    // widest per relation count (up to 511 distinct ideals)
    localparam int NCNT_W    = 9;
    // index extended wide enough to compare against the largest table size
    localparam int EXT_W     = 25;
    // signed width of the excess arithmetic
    localparam int EXC_W     = 23;

    localparam logic [KEPT_W-1:0]  KEPT_MAX  = 20'hFFFFF;
    localparam logic [COVER_W-1:0] COVER_MAX = 17'h1FFFF;
    localparam logic [NEWO_W-1:0]  NEWO_MAX  = 6'h3F;

    // bit positions in one ideal map entry
    localparam int MAP_PEND = 0;
    localparam int MAP_SEEN = 1;
    localparam int MAP_W    = 2;

    // one result beat
    typedef struct packed {
        logic               overflow;
        logic               stopped;
        logic [COVER_W-1:0] total_ideals;
        logic [KEPT_W-1:0]  kept_relations;
        logic [NEWO_W-1:0]  new_ideals;
        logic               keep;
    } t_result;

endpackage

### design/greedy_relation_excess_filter_top.sv
// ----------------------------------------------------------------------------
// greedy_relation_excess_filter_top
// greedy relation filter: keeps a relation while ideals outrun kept relations
// ----------------------------------------------------------------------------
// After reset the block sweeps its ideal map clear, one entry a cycle;
// s_axis_tready stays low until that is done (the config channel is open
// throughout). Each ideal beat then passes S_IDLE, which reads the
// seen/pending map, and S_LOOK, which updates it, bounded by the single map
// read and write port. The beat carrying tlast adds S_DECIDE, then a commit
// walk over the relation buffer (S_WALK_RD and S_WALK_WR per distinct
// buffered ideal), then S_FINISH, which holds the result until the output
// register takes it. Once the excess falls below the target the block
// raises stopped and drops every later beat without a result.
module greedy_relation_excess_filter_top
    import grefilt_pkg::*;
#(
    parameter int NUM_IDEALS     = NUM_IDEALS_DEF,
    parameter int MAX_REL_IDEALS = MAX_REL_IDEALS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,       // required excess target (signed)
    // ideal stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // ideal_index[15:0]
    input  logic        i_s_axis_tlast,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // keep[0], new_ideals[6:1], kept_relations[26:7], total_ideals[43:27],
    // stopped[44], overflow[45], zero[47:46]
    output logic [47:0] o_m_axis_tdata
);

    logic signed [TGT_W-1:0] r_target;
    logic                    r_out_valid;
    t_result                 r_out;
    logic                    res_valid;
    logic                    res_ready;
    t_result                 res;

    // target register, writable any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_target <= i_cfg_data;
        end
    end

    // sequencer and datapath
    grefilt_ctrl #(
        .NUM_IDEALS     (NUM_IDEALS),
        .MAX_REL_IDEALS (MAX_REL_IDEALS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_ideal_index (i_s_axis_tdata),
        .i_last        (i_s_axis_tlast),
        .i_target      (r_target),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    // output register
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out};

endmodule

### design/grefilt_ram.sv
// ----------------------------------------------------------------------------
// grefilt_ram
// generic simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module grefilt_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/grefilt_excess.sv
// ----------------------------------------------------------------------------
// grefilt_excess
// shared excess compare: a + b - c >= target, exact signed arithmetic
// ----------------------------------------------------------------------------
module grefilt_excess
    import grefilt_pkg::*;
(
    input  logic [NCNT_W-1:0]      i_a,
    input  logic [COVER_W-1:0]     i_b,
    input  logic [KEPT_W-1:0]      i_c,
    input  logic signed [TGT_W-1:0] i_target,
    output logic                   o_ge
);

    logic signed [EXC_W-1:0] sa;
    logic signed [EXC_W-1:0] sb;
    logic signed [EXC_W-1:0] sc;
    logic signed [EXC_W-1:0] st;
    logic signed [EXC_W-1:0] diff;

    // zero extend the counts, sign extend the target
    assign sa   = $signed(EXC_W'(i_a));
    assign sb   = $signed(EXC_W'(i_b));
    assign sc   = $signed(EXC_W'(i_c));
    assign st   = EXC_W'(i_target);
    assign diff = sa + sb - sc;
    assign o_ge = (diff >= st);

endmodule

### design/grefilt_ctrl.sv
// ----------------------------------------------------------------------------
// grefilt_ctrl
// sequencer: map clearing, per ideal lookup, keep decision and commit walk
// ----------------------------------------------------------------------------
`include "greedy_relation_excess_filter_top_macros.svh"

module grefilt_ctrl
    import grefilt_pkg::*;
#(
    parameter int NUM_IDEALS     = NUM_IDEALS_DEF,
    parameter int MAX_REL_IDEALS = MAX_REL_IDEALS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [IDX_IN_W-1:0]     i_ideal_index,
    input  logic                    i_last,
    input  logic signed [TGT_W-1:0] i_target,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output t_result                 o_res
);

    localparam int IDX_W  = $clog2(NUM_IDEALS);
    localparam int CNT_W  = $clog2(MAX_REL_IDEALS + 1);
    localparam int BUF_AW = (MAX_REL_IDEALS > 1) ? $clog2(MAX_REL_IDEALS) : 1;
    localparam int BUF_DW = IDX_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_DECIDE,
        S_WALK_RD,
        S_WALK_WR,
        S_FINISH
    } t_state;

    t_state             r_state,    n_state;
    logic [IDX_W-1:0]   r_clr_addr, n_clr_addr;
    logic [IDX_W-1:0]   r_addr,     n_addr;
    logic               r_hit,      n_hit;
    logic               r_last,     n_last;
    logic [CNT_W-1:0]   r_buf_cnt,  n_buf_cnt;
    logic [CNT_W-1:0]   r_new_cnt,  n_new_cnt;
    logic               r_ovf,      n_ovf;
    logic [KEPT_W-1:0]  r_kept,     n_kept;
    logic [COVER_W-1:0] r_cover,    n_cover;
    logic               r_halted,   n_halted;
    logic               r_keep,     n_keep;
    logic [CNT_W-1:0]   r_walk,     n_walk;

    logic               in_acc;
    logic [EXT_W-1:0]   idx_ext;
    logic               idx_hit;

    logic               map_we;
    logic [IDX_W-1:0]   map_waddr;
    logic [MAP_W-1:0]   map_wdata;
    logic               map_re;
    logic [MAP_W-1:0]   map_rdata;

    logic               buf_we;
    logic [BUF_DW-1:0]  buf_wdata;
    logic               buf_re;
    logic [BUF_DW-1:0]  buf_rdata;

    logic [NCNT_W-1:0]  new_ext;
    logic [NCNT_W-1:0]  cmp_a;
    logic               cmp_ge;
    logic [COVER_W:0]   cover_sum;

    // input index range check and map address
    assign idx_ext = EXT_W'(i_ideal_index);
    assign idx_hit = (idx_ext < EXT_W'(NUM_IDEALS));
    assign in_acc  = i_in_valid && o_in_ready;

    assign o_in_ready = (r_state == S_IDLE);
    assign map_re     = in_acc;

    // seen and pending bits of every ideal
    grefilt_ram #(
        .DW    (MAP_W),
        .DEPTH (NUM_IDEALS),
        .AW    (IDX_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (idx_ext[IDX_W-1:0]),
        .o_rdata (map_rdata)
    );

    // distinct ideals of the open relation with their old seen bit
    grefilt_ram #(
        .DW    (BUF_DW),
        .DEPTH (MAX_REL_IDEALS),
        .AW    (BUF_AW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_buf_cnt[BUF_AW-1:0]),
        .i_wdata (buf_wdata),
        .i_re    (buf_re),
        .i_raddr (r_walk[BUF_AW-1:0]),
        .o_rdata (buf_rdata)
    );

    // shared excess compare: keep test in decide, stop test in finish
    assign new_ext = NCNT_W'(r_new_cnt);
    assign cmp_a   = (r_state == S_DECIDE) ? new_ext : '0;

    grefilt_excess u_excess (
        .i_a      (cmp_a),
        .i_b      (r_cover),
        .i_c      (r_kept),
        .i_target (i_target),
        .o_ge     (cmp_ge)
    );

    assign cover_sum = (COVER_W + 1)'(r_cover) + (COVER_W + 1)'(r_new_cnt);

    // ram port control
    always_comb begin
        map_we    = 1'b0;
        map_waddr = r_addr;
        map_wdata = '0;
        buf_we    = 1'b0;
        buf_wdata = {map_rdata[MAP_SEEN], r_addr};
        buf_re    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr_addr;
            end
            S_LOOK: begin
                if (r_hit && !map_rdata[MAP_PEND] &&
                    (r_buf_cnt < CNT_W'(MAX_REL_IDEALS))) begin
                    map_we              = 1'b1;
                    map_wdata[MAP_SEEN] = map_rdata[MAP_SEEN];
                    map_wdata[MAP_PEND] = 1'b1;
                    buf_we              = 1'b1;
                end
            end
            S_WALK_RD: begin
                buf_re = 1'b1;
            end
            S_WALK_WR: begin
                map_we              = 1'b1;
                map_waddr           = buf_rdata[IDX_W-1:0];
                map_wdata[MAP_SEEN] = buf_rdata[IDX_W] | r_keep;
                map_wdata[MAP_PEND] = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // result beat
    always_comb begin
        o_res_valid          = (r_state == S_FINISH);
        o_res.keep           = r_keep;
        o_res.new_ideals     = (new_ext > NCNT_W'(NEWO_MAX)) ? NEWO_MAX
                                                             : new_ext[NEWO_W-1:0];
        o_res.kept_relations = r_kept;
        o_res.total_ideals   = r_cover;
        o_res.stopped        = !cmp_ge;
        o_res.overflow       = r_ovf;
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_addr     = r_addr;
        n_hit      = r_hit;
        n_last     = r_last;
        n_buf_cnt  = r_buf_cnt;
        n_new_cnt  = r_new_cnt;
        n_ovf      = r_ovf;
        n_kept     = r_kept;
        n_cover    = r_cover;
        n_halted   = r_halted;
        n_keep     = r_keep;
        n_walk     = r_walk;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == IDX_W'(NUM_IDEALS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // after a stop every beat is dropped here
                if (in_acc && !r_halted) begin
                    n_addr  = idx_ext[IDX_W-1:0];
                    n_hit   = idx_hit;
                    n_last  = i_last;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (r_hit && !map_rdata[MAP_PEND]) begin
                    if (r_buf_cnt < CNT_W'(MAX_REL_IDEALS)) begin
                        n_buf_cnt = r_buf_cnt + 1'b1;
                        if (!map_rdata[MAP_SEEN]) begin
                            n_new_cnt = r_new_cnt + 1'b1;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_state = r_last ? S_DECIDE : S_IDLE;
            end
            S_DECIDE: begin
                n_keep = cmp_ge;
                if (cmp_ge) begin
                    if (r_kept != KEPT_MAX) begin
                        n_kept = r_kept + 1'b1;
                    end
                    n_cover = (cover_sum > (COVER_W + 1)'(COVER_MAX)) ? COVER_MAX
                                                                     : cover_sum[COVER_W-1:0];
                end
                n_walk  = '0;
                n_state = (r_buf_cnt == '0) ? S_FINISH : S_WALK_RD;
            end
            S_WALK_RD: begin
                n_state = S_WALK_WR;
            end
            S_WALK_WR: begin
                n_walk  = r_walk + 1'b1;
                n_state = (r_walk == r_buf_cnt - 1'b1) ? S_FINISH : S_WALK_RD;
            end
            S_FINISH: begin
                if (i_res_ready) begin
                    n_halted  = !cmp_ge;
                    n_buf_cnt = '0;
                    n_new_cnt = '0;
                    n_ovf     = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_hit      <= 1'b0;
            r_last     <= 1'b0;
            r_buf_cnt  <= '0;
            r_new_cnt  <= '0;
            r_ovf      <= 1'b0;
            r_kept     <= '0;
            r_cover    <= '0;
            r_halted   <= 1'b0;
            r_keep     <= 1'b0;
            r_walk     <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_hit      <= n_hit;
            r_last     <= n_last;
            r_buf_cnt  <= n_buf_cnt;
            r_new_cnt  <= n_new_cnt;
            r_ovf      <= n_ovf;
            r_kept     <= n_kept;
            r_cover    <= n_cover;
            r_halted   <= n_halted;
            r_keep     <= n_keep;
            r_walk     <= n_walk;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
    end

    // checks
    `GRF_ASSERT(a_buf_bound, i_clk, i_rst_n, r_buf_cnt <= CNT_W'(MAX_REL_IDEALS), "buffer count past its depth")
    `GRF_ASSERT(a_new_le_buf, i_clk, i_rst_n, r_new_cnt <= r_buf_cnt, "more new ideals than buffered ideals")
    `GRF_ASSERT(a_kept_mono, i_clk, i_rst_n, r_kept >= $past(r_kept), "kept count went down")
    `GRF_ASSERT(a_cover_mono, i_clk, i_rst_n, r_cover >= $past(r_cover), "covered count went down")
    `GRF_ASSERT_IMP(a_walk_clears, i_clk, i_rst_n, r_state == S_WALK_WR, map_we && !map_wdata[MAP_PEND], "commit walk left a pending bit")

endmodule
